[design/hne_pkg.sv]
// hne_pkg: shared constants, codes and types of the heightmap normal engine
// no dependencies; used by every other design file
package hne_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_LENGTH = 128;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 7;
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int CELLS      = MAX_WIDTH * MAX_LENGTH;
  localparam int SIZE_W     = 8;
  localparam int SCALE_W    = 16;
  localparam int SAMPLE_W   = 8;
  localparam int HEIGHT_W   = 18;
  localparam int NORM_W     = 19;
  localparam int UNIT_W     = 16;
  localparam int VEC_W      = 3 * NORM_W;

  localparam logic [SIZE_W-1:0]          MAX_WIDTH_SZ  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0]          MAX_LENGTH_SZ = SIZE_W'(MAX_LENGTH);
  localparam logic signed [NORM_W-1:0]   ONE_Q14       = NORM_W'(16384);
  localparam logic [23:0]                RECIP_510     = 24'd8421504;  // floor(2^32/510)

  // input item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // configuration register indexes
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [1:0] REG_GRID_LENGTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_READ,
    CMD_DFLT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                     op;
    logic [ADDR_W-1:0]           addr;
    logic signed [HEIGHT_W-1:0]  height;
  } cmd_t;

endpackage

[design/hne_if.sv]
// hne_req_if / hne_resp_if: valid-ready channels of the heightmap normal engine
// depends on hne_pkg for field widths
interface hne_req_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [hne_pkg::COL_W-1:0]      column;
  logic [hne_pkg::ROW_W-1:0]      row;
  logic [hne_pkg::SAMPLE_W-1:0]   sample;
  modport source(output valid, mode, column, row, sample, input ready);
  modport sink(input valid, mode, column, row, sample, output ready);
endinterface

interface hne_resp_if;
  logic                               valid;
  logic                               ready;
  logic signed [hne_pkg::NORM_W-1:0]  normal_x;
  logic signed [hne_pkg::NORM_W-1:0]  normal_y;
  logic signed [hne_pkg::NORM_W-1:0]  normal_z;
  modport source(output valid, normal_x, normal_y, normal_z, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, output ready);
endinterface

[design/hne_front.sv]
// hne_front: accepts words, classifies them and converts load bytes to heights
// depends on hne_pkg and hne_req_if
module hne_front (
  input  logic                              clk,
  input  logic                              rst,
  hne_req_if.sink                           req,
  input  logic [hne_pkg::SIZE_W-1:0]        eff_w,
  input  logic [hne_pkg::SIZE_W-1:0]        eff_l,
  input  logic [hne_pkg::SCALE_W-1:0]       height_scale,
  output hne_pkg::cmd_t                     push_cmd,
  output logic                              push_valid,
  input  logic                              push_ready
);

  typedef enum logic [2:0] {
    F_IDLE, F_SCALE, F_RECIP, F_QUOT, F_BACK, F_FIX, F_PUSH
  } fstate_t;

  fstate_t      state;
  logic         neg;
  logic [7:0]   mag8;
  logic [24:0]  mm;
  logic [48:0]  prod;
  logic [16:0]  q0;
  logic [25:0]  qm;
  hne_pkg::cmd_t cmd;

  logic         in_grid;
  logic [9:0]   diff;
  logic [24:0]  rem;
  logic [16:0]  quo;

  assign in_grid = ({1'b0, req.column} < eff_w) && ({1'b0, req.row} < eff_l);
  assign diff    = {1'b0, req.sample, 1'b0} - 10'd255;
  assign rem     = mm - qm[24:0];
  assign quo     = (rem >= 25'd510) ? q0 + 17'd1 : q0;

  assign req.ready  = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (req.valid) begin
            cmd.addr   <= {req.row, req.column};
            cmd.height <= '0;
            if (req.mode == hne_pkg::MODE_LOAD) begin
              cmd.op <= hne_pkg::CMD_LOAD;
              neg    <= diff[9];
              mag8   <= diff[9] ? 8'(-diff) : diff[7:0];
              if (in_grid) state <= F_SCALE;
            end else begin
              cmd.op <= in_grid ? hne_pkg::CMD_READ : hne_pkg::CMD_DFLT;
              state  <= F_PUSH;
            end
          end
        end
        F_SCALE: begin
          mm    <= 25'(height_scale * mag8) + 25'd255;
          state <= F_RECIP;
        end
        F_RECIP: begin
          prod  <= mm * hne_pkg::RECIP_510;
          state <= F_QUOT;
        end
        F_QUOT: begin
          q0    <= prod[48:32];
          state <= F_BACK;
        end
        F_BACK: begin
          qm    <= q0 * 9'd510;
          state <= F_FIX;
        end
        F_FIX: begin
          cmd.height <= neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
          state      <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[design/hne_fifo.sv]
// hne_fifo: short command queue between front and back
// depends on hne_pkg
module hne_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hne_pkg::cmd_t  push_cmd,
  output logic           not_full,
  input  logic           pop,
  output hne_pkg::cmd_t  head,
  output logic           not_empty
);

  hne_pkg::cmd_t                   slots [hne_pkg::QDEPTH];
  logic [hne_pkg::QPTR_W-1:0]      wptr;
  logic [hne_pkg::QPTR_W-1:0]      rptr;
  logic [hne_pkg::QPTR_W:0]        count;

  assign not_full  = (count != (hne_pkg::QPTR_W+1)'(hne_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && not_full) slots[wptr] <= push_cmd;
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && not_full) wptr <= wptr + 1'b1;
      if (pop && not_empty) rptr <= rptr + 1'b1;
      count <= count + (hne_pkg::QPTR_W+1)'(push && not_full)
                     - (hne_pkg::QPTR_W+1)'(pop && not_empty);
    end
  end

endmodule

[design/hne_unit.sv]
// hne_unit: makes (a,1,b) in q8.8 a unit vector in q2.14 by bit-serial root and division
// depends on hne_pkg
module hne_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [hne_pkg::HEIGHT_W-1:0]  a,
  input  logic signed [hne_pkg::HEIGHT_W-1:0]  b,
  output logic                                 done,
  output logic signed [hne_pkg::UNIT_W-1:0]    ux,
  output logic signed [hne_pkg::UNIT_W-1:0]    uy,
  output logic signed [hne_pkg::UNIT_W-1:0]    uz
);

  typedef enum logic [2:0] {
    U_IDLE, U_SQ, U_SUM, U_ROOT, U_DINIT, U_DIV, U_DONE
  } ustate_t;

  ustate_t state;
  logic signed [hne_pkg::HEIGHT_W-1:0] a_r, b_r;
  logic [35:0]  sq_a, sq_b;
  logic [63:0]  v, res, bitv;
  logic [4:0]   cnt;
  logic [31:0]  s;
  logic [32:0]  rem  [3];
  logic [15:0]  low  [3];
  logic [15:0]  quo  [3];
  logic         neg  [3];

  logic signed [35:0] a_sq_w, b_sq_w;
  logic [63:0]  trial;
  logic [16:0]  mag  [3];
  logic [45:0]  num  [3];
  logic [32:0]  sh   [3];

  assign a_sq_w = a_r * a_r;
  assign b_sq_w = b_r * b_r;
  assign trial  = res + bitv;

  assign mag[0] = a_r[hne_pkg::HEIGHT_W-1] ? 17'(-a_r) : a_r[16:0];
  assign mag[1] = 17'd256;
  assign mag[2] = b_r[hne_pkg::HEIGHT_W-1] ? 17'(-b_r) : b_r[16:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, mag[i], 28'b0} + {15'b0, res[31:1]};
      sh[i]  = {rem[i][31:0], low[i][15]};
    end
  end

  assign done = (state == U_DONE);
  assign ux   = neg[0] ? -$signed(quo[0]) : $signed(quo[0]);
  assign uy   = $signed(quo[1]);
  assign uz   = neg[2] ? -$signed(quo[2]) : $signed(quo[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      unique case (state)
        U_IDLE: begin
          if (start) begin
            a_r   <= a;
            b_r   <= b;
            state <= U_SQ;
          end
        end
        U_SQ: begin
          sq_a  <= a_sq_w;
          sq_b  <= b_sq_w;
          state <= U_SUM;
        end
        U_SUM: begin
          v     <= ({28'b0, sq_a} + {28'b0, sq_b} + 64'd65536) << 28;
          res   <= '0;
          bitv  <= 64'h4000_0000_0000_0000;
          cnt   <= '0;
          state <= U_ROOT;
        end
        U_ROOT: begin
          if (v >= trial) begin
            v   <= v - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) state <= U_DINIT;
        end
        U_DINIT: begin
          s <= res[31:0];
          for (int i = 0; i < 3; i++) begin
            rem[i] <= {3'b0, num[i][45:16]};
            low[i] <= num[i][15:0];
            quo[i] <= '0;
          end
          neg[0] <= a_r[hne_pkg::HEIGHT_W-1];
          neg[1] <= 1'b0;
          neg[2] <= b_r[hne_pkg::HEIGHT_W-1];
          cnt    <= '0;
          state  <= U_DIV;
        end
        U_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (sh[i] >= {1'b0, s}) begin
              rem[i] <= sh[i] - {1'b0, s};
              quo[i] <= {quo[i][14:0], 1'b1};
            end else begin
              rem[i] <= sh[i];
              quo[i] <= {quo[i][14:0], 1'b0};
            end
            low[i] <= {low[i][14:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) state <= U_DONE;
        end
        U_DONE: state <= U_IDLE;
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

[design/hne_back.sv]
// hne_back: executes queued commands, holds the grid memories and runs the recompute
// depends on hne_pkg, hne_resp_if and hne_unit
module hne_back (
  input  logic                        clk,
  input  logic                        rst,
  input  hne_pkg::cmd_t               head,
  input  logic                        not_empty,
  output logic                        pop,
  input  logic [hne_pkg::SIZE_W-1:0]  eff_w,
  input  logic [hne_pkg::SIZE_W-1:0]  eff_l,
  input  logic                        size_write,
  hne_resp_if.source                  resp
);

  localparam logic [2:0] NB_OWN = 3'd0;
  localparam logic [2:0] NB_L   = 3'd1;
  localparam logic [2:0] NB_R   = 3'd2;
  localparam logic [2:0] NB_O   = 3'd3;
  localparam logic [2:0] NB_I   = 3'd4;

  localparam int HW = hne_pkg::HEIGHT_W;
  localparam int NW = hne_pkg::NORM_W;
  localparam int TW = NW + 2;

  typedef enum logic [3:0] {
    B_IDLE, B_H_REQ, B_H_CAP, B_QUAD, B_QWAIT, B_RWR,
    B_N_REQ, B_N_CAP, B_SWR, B_RD_REQ, B_RD_WAIT, B_OUT
  } bstate_t;

  bstate_t state;
  logic    stale;

  logic [HW-1:0]                    hmem [hne_pkg::CELLS];
  logic [hne_pkg::VEC_W-1:0]        rmem [hne_pkg::CELLS];
  logic [hne_pkg::VEC_W-1:0]        smem [hne_pkg::CELLS];
  logic [HW-1:0]                    h_rdata;
  logic [hne_pkg::VEC_W-1:0]        r_rdata, s_rdata;
  logic [hne_pkg::ADDR_W-1:0]       rd_addr;

  logic [hne_pkg::COL_W-1:0]        x;
  logic [hne_pkg::ROW_W-1:0]        z;
  logic [2:0]                       k;
  logic [1:0]                       q;
  logic [hne_pkg::ADDR_W-1:0]       cur_addr;
  logic signed [HW-1:0]             nbv [5];
  logic signed [NW-1:0]             acc [3];
  logic signed [TW-1:0]             tsum [3];
  logic signed [NW-1:0]             res [3];
  logic signed [NW-1:0]             out_n [3];
  logic                             out_valid;

  logic has_l, has_r, has_o, has_i, x_last, z_last, nb_exists, quad_en;
  logic signed [HW-1:0] d_l, d_r, d_o, d_i, ua, ub;
  logic [hne_pkg::ADDR_W-1:0] cell_addr, nb_addr;
  logic signed [NW-1:0] rv [3];
  logic signed [NW-1:0] sm [3];
  logic [TW-1:0] smag [3];
  logic [TW-1:0] shalf [3];
  logic unit_start, unit_done;
  logic signed [hne_pkg::UNIT_W-1:0] ux, uy, uz;
  logic signed [hne_pkg::UNIT_W-1:0] uvec [3];

  assign has_l     = (x != '0);
  assign has_o     = (z != '0);
  assign has_r     = (({1'b0, x} + 8'd1) < eff_w);
  assign has_i     = (({1'b0, z} + 8'd1) < eff_l);
  assign x_last    = (({1'b0, x} + 8'd1) == eff_w);
  assign z_last    = (({1'b0, z} + 8'd1) == eff_l);
  assign cell_addr = {z, x};

  always_comb begin
    unique case (k)
      NB_L:    begin nb_addr = {z, x - 1'b1};  nb_exists = has_l; end
      NB_R:    begin nb_addr = {z, x + 1'b1};  nb_exists = has_r; end
      NB_O:    begin nb_addr = {z - 1'b1, x};  nb_exists = has_o; end
      NB_I:    begin nb_addr = {z + 1'b1, x};  nb_exists = has_i; end
      default: begin nb_addr = cell_addr;      nb_exists = 1'b1;  end
    endcase
  end

  assign d_l = nbv[1] - nbv[0];
  assign d_r = nbv[2] - nbv[0];
  assign d_o = nbv[3] - nbv[0];
  assign d_i = nbv[4] - nbv[0];

  // quads: left/out, left/in, in/right, right/out
  always_comb begin
    unique case (q)
      2'd0:    begin quad_en = has_l & has_o; ua = d_l;  ub = d_o;  end
      2'd1:    begin quad_en = has_l & has_i; ua = d_l;  ub = -d_i; end
      2'd2:    begin quad_en = has_r & has_i; ua = -d_r; ub = -d_i; end
      default: begin quad_en = has_r & has_o; ua = -d_r; ub = d_o;  end
    endcase
  end

  assign unit_start = (state == B_QUAD) && quad_en;
  assign uvec[0] = ux;
  assign uvec[1] = uy;
  assign uvec[2] = uz;

  hne_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .a     (ua),
    .b     (ub),
    .done  (unit_done),
    .ux    (ux),
    .uy    (uy),
    .uz    (uz)
  );

  assign rv[0] = r_rdata[3*NW-1:2*NW];
  assign rv[1] = r_rdata[2*NW-1:NW];
  assign rv[2] = r_rdata[NW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      smag[i]  = tsum[i][TW-1] ? TW'(-tsum[i]) : tsum[i];
      shalf[i] = (smag[i] + TW'(1)) >> 1;
      sm[i]    = tsum[i][TW-1] ? -$signed(shalf[i][NW-1:0]) : $signed(shalf[i][NW-1:0]);
    end
  end

  always_comb begin
    unique case (state)
      B_H_REQ, B_N_REQ: rd_addr = nb_addr;
      default:          rd_addr = cur_addr;
    endcase
  end

  assign pop = (state == B_IDLE) && not_empty;

  // memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (pop && head.op == hne_pkg::CMD_LOAD) hmem[head.addr] <= head.height;
    if (state == B_RWR) rmem[cell_addr] <= {acc[0], acc[1], acc[2]};
    if (state == B_SWR) begin
      if (sm[0] == '0 && sm[1] == '0 && sm[2] == '0)
        smem[cell_addr] <= {sm[0], hne_pkg::ONE_Q14, sm[2]};
      else
        smem[cell_addr] <= {sm[0], sm[1], sm[2]};
    end
    h_rdata <= hmem[rd_addr];
    r_rdata <= rmem[rd_addr];
    s_rdata <= smem[rd_addr];
  end

  assign resp.valid    = out_valid;
  assign resp.normal_x = out_n[0];
  assign resp.normal_y = out_n[1];
  assign resp.normal_z = out_n[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      stale     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (size_write) stale <= 1'b1;
      if (out_valid && resp.ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (not_empty) begin
            cur_addr <= head.addr;
            unique case (head.op)
              hne_pkg::CMD_LOAD: stale <= 1'b1;
              hne_pkg::CMD_READ: begin
                if (stale) begin
                  x     <= '0;
                  z     <= '0;
                  k     <= NB_OWN;
                  state <= B_H_REQ;
                end else begin
                  state <= B_RD_REQ;
                end
              end
              default: begin
                res[0] <= '0;
                res[1] <= hne_pkg::ONE_Q14;
                res[2] <= '0;
                state  <= B_OUT;
              end
            endcase
          end
        end
        B_H_REQ: state <= B_H_CAP;
        B_H_CAP: begin
          nbv[k] <= h_rdata;
          if (k == NB_I) begin
            q      <= 2'd0;
            acc[0] <= '0;
            acc[1] <= '0;
            acc[2] <= '0;
            state  <= B_QUAD;
          end else begin
            k     <= k + 3'd1;
            state <= B_H_REQ;
          end
        end
        B_QUAD: begin
          if (quad_en) begin
            state <= B_QWAIT;
          end else if (q == 2'd3) begin
            state <= B_RWR;
          end else begin
            q <= q + 2'd1;
          end
        end
        B_QWAIT: begin
          if (unit_done) begin
            for (int i = 0; i < 3; i++)
              acc[i] <= acc[i] + NW'(uvec[i]);
            if (q == 2'd3) begin
              state <= B_RWR;
            end else begin
              q     <= q + 2'd1;
              state <= B_QUAD;
            end
          end
        end
        B_RWR: begin
          k <= NB_OWN;
          if (x_last) begin
            x <= '0;
            if (z_last) begin
              z     <= '0;
              state <= B_N_REQ;
            end else begin
              z     <= z + 1'b1;
              state <= B_H_REQ;
            end
          end else begin
            x     <= x + 1'b1;
            state <= B_H_REQ;
          end
        end
        B_N_REQ: state <= B_N_CAP;
        B_N_CAP: begin
          for (int i = 0; i < 3; i++) begin
            if (k == NB_OWN)
              tsum[i] <= TW'(rv[i]) <<< 1;
            else if (nb_exists)
              tsum[i] <= tsum[i] + TW'(rv[i]);
          end
          if (k == NB_I) begin
            state <= B_SWR;
          end else begin
            k     <= k + 3'd1;
            state <= B_N_REQ;
          end
        end
        B_SWR: begin
          k <= NB_OWN;
          if (x_last) begin
            x <= '0;
            if (z_last) begin
              stale <= 1'b0;
              state <= B_RD_REQ;
            end else begin
              z     <= z + 1'b1;
              state <= B_N_REQ;
            end
          end else begin
            x     <= x + 1'b1;
            state <= B_N_REQ;
          end
        end
        B_RD_REQ: state <= B_RD_WAIT;
        B_RD_WAIT: begin
          res[0] <= s_rdata[3*NW-1:2*NW];
          res[1] <= s_rdata[2*NW-1:NW];
          res[2] <= s_rdata[NW-1:0];
          state  <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid || resp.ready) begin
            out_n[0]  <= res[0];
            out_n[1]  <= res[1];
            out_n[2]  <= res[2];
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[design/heightmap_normal_engine.sv]
// heightmap_normal_engine: top level, configuration registers and block wiring
// depends on hne_pkg, hne_if, hne_front, hne_fifo, hne_back
//
// Terrain height grid (up to 128 x 128) with smoothed vertex normals on demand.
// A load word (mode 0) turns its sample byte into a signed q8.8 height
// scale*(byte/255 - 0.5) and stores it at (column,row); loads outside the grid
// in use are dropped. A read word (mode 1) returns one response word with the
// q5.14 normal; reads outside the grid return (0,1.0,0). Words are taken by a
// front end that classifies them and converts heights, and pass through a
// four-deep queue to the back end, which owns the height, rough-normal and
// smooth-normal memories (one write and one registered read port each). A clean
// read issues a smooth-normal memory read and moves the result to the output register;
// the response register lets the next word proceed while a result waits. Any
// stored load or grid size write marks the normals stale, and the next in-grid
// read first recomputes the whole grid: per cell, height reads of the cell and
// its neighbours, then each adjacent quad in the shared unit-vector unit
// (32-step square root then 16-step divides), then a smoothing pass over every
// cell. Writes to the height scale only affect later loads. Registers:
// grid_width at 0x0, grid_length at 0x4, height_scale at 0x8; sizes are clamped
// to 1..128.
module heightmap_normal_engine (
  input  logic                          clk,
  input  logic                          rst,
  hne_req_if.sink                       req,
  hne_resp_if.source                    resp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hne_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [hne_pkg::SIZE_W-1:0]   grid_width;
  logic [hne_pkg::SIZE_W-1:0]   grid_length;
  logic [hne_pkg::SCALE_W-1:0]  height_scale;
  logic [hne_pkg::SIZE_W-1:0]   eff_w, eff_l;
  logic [1:0]                   reg_idx;
  logic                         cfg_wr;
  logic                         size_write;

  hne_pkg::cmd_t                push_cmd, head;
  logic                         push_valid, push_ready, not_empty, pop;

  // clamp a size register into 1..max
  function automatic logic [hne_pkg::SIZE_W-1:0] clamp_size(
    input logic [hne_pkg::SIZE_W-1:0] val,
    input logic [hne_pkg::SIZE_W-1:0] max_sz
  );
    logic [hne_pkg::SIZE_W-1:0] r;
    if (val == '0)
      r = hne_pkg::SIZE_W'(1);
    else if (val > max_sz)
      r = max_sz;
    else
      r = val;
    return r;
  endfunction

  assign eff_w   = clamp_size(grid_width, hne_pkg::MAX_WIDTH_SZ);
  assign eff_l   = clamp_size(grid_length, hne_pkg::MAX_LENGTH_SZ);
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  // either size register change invalidates the computed normals
  assign size_write = cfg_wr &&
                      (reg_idx == hne_pkg::REG_GRID_WIDTH ||
                       reg_idx == hne_pkg::REG_GRID_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= hne_pkg::MAX_WIDTH_SZ;
      grid_length  <= hne_pkg::MAX_LENGTH_SZ;
      height_scale <= 16'd5120;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        hne_pkg::REG_GRID_WIDTH:   grid_width   <= pwdata[hne_pkg::SIZE_W-1:0];
        hne_pkg::REG_GRID_LENGTH:  grid_length  <= pwdata[hne_pkg::SIZE_W-1:0];
        hne_pkg::REG_HEIGHT_SCALE: height_scale <= pwdata[hne_pkg::SCALE_W-1:0];
        default: ;  // unmapped address, write ignored
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      hne_pkg::REG_GRID_WIDTH:   prdata = {24'b0, grid_width};
      hne_pkg::REG_GRID_LENGTH:  prdata = {24'b0, grid_length};
      hne_pkg::REG_HEIGHT_SCALE: prdata = {16'b0, height_scale};
      default:                   prdata = '0;
    endcase
  end

  // front end: accept, classify, convert height bytes
  hne_front u_front (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .eff_w        (eff_w),
    .eff_l        (eff_l),
    .height_scale (height_scale),
    .push_cmd     (push_cmd),
    .push_valid   (push_valid),
    .push_ready   (push_ready)
  );

  // decouples the front end from long back-end recomputes
  hne_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_cmd  (push_cmd),
    .not_full  (push_ready),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  // back end: memories, recompute sequencer, response register
  hne_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .not_empty  (not_empty),
    .pop        (pop),
    .eff_w      (eff_w),
    .eff_l      (eff_l),
    .size_write (size_write),
    .resp       (resp)
  );

endmodule
